@@ rtl/pfh_pkg.sv @@
package pfh_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int COORD_BITS_DEF = 24;
    localparam int AREA_W         = 64;
    localparam int COUNT_OUT_W    = 7;
    localparam int CFG_IDX_W      = 2;

    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_DOMINATED = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_CLEARED   = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_REF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 2'd1;

    typedef logic [2:0] cell_cmd_t;
    localparam cell_cmd_t CMD_NONE = 3'd0;
    localparam cell_cmd_t CMD_INS  = 3'd1;
    localparam cell_cmd_t CMD_SETY = 3'd2;
    localparam cell_cmd_t CMD_SETS = 3'd3;
    localparam cell_cmd_t CMD_DEL  = 3'd4;

    typedef logic signed [AREA_W-1:0] area_t;

    localparam area_t AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam area_t AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

    function automatic area_t sat_add(area_t a, area_t b);
        logic [AREA_W:0] s;
        s = {a[AREA_W-1], a} + {b[AREA_W-1], b};
        if (s[AREA_W] != s[AREA_W-1])
        begin
            return s[AREA_W] ? AREA_MIN : AREA_MAX;
        end
        return area_t'(s[AREA_W-1:0]);
    endfunction

    function automatic area_t sat_sub(area_t a, area_t b);
        logic [AREA_W:0] s;
        s = {a[AREA_W-1], a} - {b[AREA_W-1], b};
        if (s[AREA_W] != s[AREA_W-1])
        begin
            return s[AREA_W] ? AREA_MIN : AREA_MAX;
        end
        return area_t'(s[AREA_W-1:0]);
    endfunction

endpackage

@@ rtl/pfh_front.sv @@
module pfh_front #(
    parameter int COORD_BITS = pfh_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic signed [COORD_BITS-1:0] cand_x,
    input  logic signed [COORD_BITS-1:0] cand_y,
    output logic                         q_valid,
    output logic                         q_clear,
    output logic signed [COORD_BITS-1:0] q_x,
    output logic signed [COORD_BITS-1:0] q_y,
    input  logic                         q_pop
);

    localparam int W = 1 + 2 * COORD_BITS;

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;
    logic         push;
    logic         pop;
    logic [W-1:0] head;

    assign busy    = (fill_reg == 2'd2);
    assign push    = start && !busy;
    assign pop     = q_pop && (fill_reg != 2'd0);
    assign q_valid = (fill_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign q_clear = (head[W-1] == pfh_pkg::OP_CLEAR);
    assign q_x     = $signed(head[2*COORD_BITS-1:COORD_BITS]);
    assign q_y     = $signed(head[COORD_BITS-1:0]);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= {op, cand_x, cand_y};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/pfh_cells.sv @@
module pfh_cells #(
    parameter int CAPACITY   = pfh_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = pfh_pkg::COORD_BITS_DEF,
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  pfh_pkg::cell_cmd_t           cmd,
    input  logic [CW-1:0]                idx,
    input  logic [CW-1:0]                count,
    input  logic signed [COORD_BITS-1:0] wx,
    input  logic signed [COORD_BITS-1:0] wy,
    input  pfh_pkg::area_t               ws,
    input  logic signed [COORD_BITS-1:0] key_x,
    input  logic signed [COORD_BITS-1:0] key_y,
    output logic [CW-1:0]                first_ge,
    output logic [CW-1:0]                first_le,
    output logic signed [COORD_BITS-1:0] rd_x,
    output logic signed [COORD_BITS-1:0] rd_y,
    output logic signed [COORD_BITS-1:0] rd_ynext,
    output pfh_pkg::area_t               rd_strip
);

    logic signed [COORD_BITS-1:0] x_q [CAPACITY];
    logic signed [COORD_BITS-1:0] y_q [CAPACITY];
    pfh_pkg::area_t               s_q [CAPACITY];
    logic [CW-1:0]                idx_p1;

    assign idx_p1 = idx + CW'(1);

    always_comb
    begin
        first_ge = count;
        first_le = count;
        rd_x     = '0;
        rd_y     = '0;
        rd_ynext = '0;
        rd_strip = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (CW'(i) < count && x_q[i] >= key_x)
            begin
                first_ge = CW'(i);
            end
            if (CW'(i) < count && y_q[i] <= key_y)
            begin
                first_le = CW'(i);
            end
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CW'(i) == idx)
            begin
                rd_x     = x_q[i];
                rd_y     = y_q[i];
                rd_strip = s_q[i];
            end
            if (CW'(i) == idx_p1)
            begin
                rd_ynext = y_q[i];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        localparam int PREV = (g > 0) ? g - 1 : 0;
        localparam int NEXT = (g < CAPACITY - 1) ? g + 1 : g;

        always_ff @(posedge clk)
        begin
            case (cmd)
                pfh_pkg::CMD_INS:
                begin
                    if (CW'(g) == idx)
                    begin
                        x_q[g] <= wx;
                        y_q[g] <= wy;
                        s_q[g] <= '0;
                    end
                    else if (CW'(g) > idx)
                    begin
                        x_q[g] <= x_q[PREV];
                        y_q[g] <= y_q[PREV];
                        s_q[g] <= s_q[PREV];
                    end
                end
                pfh_pkg::CMD_SETY:
                begin
                    if (CW'(g) == idx)
                    begin
                        y_q[g] <= wy;
                    end
                end
                pfh_pkg::CMD_SETS:
                begin
                    if (CW'(g) == idx)
                    begin
                        s_q[g] <= ws;
                    end
                end
                pfh_pkg::CMD_DEL:
                begin
                    if (CW'(g) >= idx)
                    begin
                        x_q[g] <= x_q[NEXT];
                        y_q[g] <= y_q[NEXT];
                        s_q[g] <= s_q[NEXT];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ rtl/pfh_back.sv @@
module pfh_back #(
    parameter int CAPACITY   = pfh_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = pfh_pkg::COORD_BITS_DEF,
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  logic                         q_clear,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    output logic                         q_pop,
    input  logic signed [COORD_BITS-1:0] ref_x,
    input  logic signed [COORD_BITS-1:0] ref_y,
    output logic                         result_valid,
    output logic [1:0]                   status,
    output pfh_pkg::area_t               total_area,
    output logic [CW-1:0]                count
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FIND = 4'd1;
    localparam logic [3:0] S_LOOK = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_SUB  = 4'd4;
    localparam logic [3:0] S_ADD  = 4'd5;
    localparam logic [3:0] S_REM  = 4'd6;
    localparam logic [3:0] S_PRED = 4'd7;

    localparam int PW = 2 * COORD_BITS + 2;

    logic [3:0]                   state_reg, state_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    pfh_pkg::area_t               sum_reg, sum_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic [CW-1:0]                rcnt_reg, rcnt_next;
    logic [CW-1:0]                tgt_reg, tgt_next;
    logic                         pred_reg, pred_next;
    logic                         done_reg, done_next;
    logic [1:0]                   status_reg, status_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [COORD_BITS:0]   dx_reg, dx_next;
    logic signed [COORD_BITS:0]   dy_reg, dy_next;
    pfh_pkg::area_t               old_reg, old_next;
    logic signed [PW-1:0]         prod_reg;
    pfh_pkg::area_t               prod_ext;

    pfh_pkg::cell_cmd_t           cmd;
    logic [CW-1:0]                idx;
    logic signed [COORD_BITS-1:0] wy;
    logic [CW-1:0]                first_ge, first_le, run_start;
    logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_ynext, ynext;
    pfh_pkg::area_t               rd_strip;
    logic                         found, same_x;

    pfh_cells #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .CW         (CW)
    ) u_cells (
        .clk      (clk),
        .cmd      (cmd),
        .idx      (idx),
        .count    (cnt_reg),
        .wx       (cx_reg),
        .wy       (wy),
        .ws       (prod_ext),
        .key_x    (cx_reg),
        .key_y    (cy_reg),
        .first_ge (first_ge),
        .first_le (first_le),
        .rd_x     (rd_x),
        .rd_y     (rd_y),
        .rd_ynext (rd_ynext),
        .rd_strip (rd_strip)
    );

    assign prod_ext     = pfh_pkg::AREA_W'(prod_reg);
    assign run_start    = (first_le < first_ge) ? first_le : first_ge;
    assign found        = (pos_reg < cnt_reg);
    assign same_x       = found && (rd_x == cx_reg);
    assign result_valid = done_reg;
    assign status       = status_reg;
    assign total_area   = sum_reg;
    assign count        = cnt_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        pos_next    = pos_reg;
        rcnt_next   = rcnt_reg;
        tgt_next    = tgt_reg;
        pred_next   = pred_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        old_next    = old_reg;
        q_pop       = 1'b0;
        cmd         = pfh_pkg::CMD_NONE;
        idx         = pos_reg;
        wy          = cy_reg;
        ynext       = ref_y;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_clear)
                    begin
                        cnt_next    = '0;
                        sum_next    = '0;
                        status_next = pfh_pkg::ST_CLEARED;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        cx_next    = q_x;
                        cy_next    = q_y;
                        state_next = S_FIND;
                    end
                end
            end
            S_FIND:
            begin
                pos_next   = first_ge;
                rcnt_next  = first_ge - run_start;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (found && rd_y >= cy_reg)
                begin
                    status_next = pfh_pkg::ST_DOMINATED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (!same_x && cnt_reg == CW'(CAPACITY))
                begin
                    status_next = pfh_pkg::ST_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    if (same_x)
                    begin
                        cmd      = pfh_pkg::CMD_SETY;
                        old_next = rd_strip;
                        if (pos_reg + CW'(1) < cnt_reg)
                        begin
                            ynext = rd_ynext;
                        end
                    end
                    else
                    begin
                        cmd      = pfh_pkg::CMD_INS;
                        cnt_next = cnt_reg + CW'(1);
                        old_next = '0;
                        if (found)
                        begin
                            ynext = rd_y;
                        end
                    end
                    dx_next    = (COORD_BITS + 1)'(cx_reg) - (COORD_BITS + 1)'(ref_x);
                    dy_next    = (COORD_BITS + 1)'(cy_reg) - (COORD_BITS + 1)'(ynext);
                    tgt_next   = pos_reg;
                    pred_next  = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SUB;
            end
            S_SUB:
            begin
                sum_next   = pfh_pkg::sat_sub(sum_reg, old_reg);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                idx      = tgt_reg;
                cmd      = pfh_pkg::CMD_SETS;
                sum_next = pfh_pkg::sat_add(sum_reg, prod_ext);
                if (pred_reg)
                begin
                    status_next = pfh_pkg::ST_ACCEPTED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (rcnt_reg != '0)
                begin
                    state_next = S_REM;
                end
                else
                begin
                    state_next = S_PRED;
                end
            end
            S_REM:
            begin
                idx       = pos_reg - CW'(1);
                cmd       = pfh_pkg::CMD_DEL;
                sum_next  = pfh_pkg::sat_sub(sum_reg, rd_strip);
                cnt_next  = cnt_reg - CW'(1);
                pos_next  = pos_reg - CW'(1);
                rcnt_next = rcnt_reg - CW'(1);
                if (rcnt_reg == CW'(1))
                begin
                    state_next = S_PRED;
                end
            end
            S_PRED:
            begin
                idx = pos_reg - CW'(1);
                if (pos_reg == '0)
                begin
                    status_next = pfh_pkg::ST_ACCEPTED;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    dx_next    = (COORD_BITS + 1)'(rd_x) - (COORD_BITS + 1)'(ref_x);
                    dy_next    = (COORD_BITS + 1)'(rd_y) - (COORD_BITS + 1)'(cy_reg);
                    old_next   = rd_strip;
                    tgt_next   = pos_reg - CW'(1);
                    pred_next  = 1'b1;
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        old_reg  <= old_next;
        pos_reg  <= pos_next;
        rcnt_reg <= rcnt_next;
        tgt_reg  <= tgt_next;
        prod_reg <= dx_reg * dy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            pred_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= pfh_pkg::ST_ACCEPTED;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
            pred_reg   <= pred_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

endmodule

@@ rtl/pareto_front_2d_hypervolume.sv @@
// Keeps a two-dimensional Pareto front of up to CAPACITY points and its hypervolume above the
// reference point, with one result item for each command item. Commands enter a two-item queue
// and busy rises only while that queue is full. Results are shown for exactly one cycle on
// result_valid and cannot be held off. A clear is answered directly from the queue, a dominated
// or full candidate after the front lookup, and an accepted insert after its strip update, one
// removal step for each front entry that it removes, and a recompute of the predecessor's strip
// when the new point has one. Strip areas come from the single shared multiplier and a
// saturating area sum, and compaction of the sorted entry chain moves by one entry per cycle.
module pareto_front_2d_hypervolume #(
    parameter int CAPACITY   = pfh_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = pfh_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              op,
    input  logic signed [COORD_BITS-1:0]      cand_x,
    input  logic signed [COORD_BITS-1:0]      cand_y,
    output logic                              result_valid,
    output logic [1:0]                        status,
    output logic signed [pfh_pkg::AREA_W-1:0] total_area,
    output logic [pfh_pkg::COUNT_OUT_W-1:0]   entry_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [COORD_BITS-1:0]             cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [COORD_BITS-1:0] ref_x_reg;
    logic signed [COORD_BITS-1:0] ref_y_reg;
    logic                         q_valid;
    logic                         q_clear;
    logic signed [COORD_BITS-1:0] q_x;
    logic signed [COORD_BITS-1:0] q_y;
    logic                         q_pop;
    logic [CW-1:0]                count;

    assign cfg_ready   = 1'b1;
    assign entry_count = pfh_pkg::COUNT_OUT_W'(count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pfh_pkg::REG_REF_X)
            begin
                ref_x_reg <= $signed(cfg_data);
            end
            else if (cfg_index == pfh_pkg::REG_REF_Y)
            begin
                ref_y_reg <= $signed(cfg_data);
            end
        end
    end

    pfh_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .op      (op),
        .cand_x  (cand_x),
        .cand_y  (cand_y),
        .q_valid (q_valid),
        .q_clear (q_clear),
        .q_x     (q_x),
        .q_y     (q_y),
        .q_pop   (q_pop)
    );

    pfh_back #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .CW         (CW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_clear      (q_clear),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_pop        (q_pop),
        .ref_x        (ref_x_reg),
        .ref_y        (ref_y_reg),
        .result_valid (result_valid),
        .status       (status),
        .total_area   (total_area),
        .count        (count)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(CAPACITY))
        else $error("front count exceeds capacity");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == pfh_pkg::ST_CLEARED |-> count == '0 && total_area == '0)
        else $error("clear left a nonempty front");

    a_accept_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == pfh_pkg::ST_ACCEPTED |-> count != '0)
        else $error("accepted item left an empty front");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

class front_scoreboard;
    int unsigned capacity;
    logic signed [23:0] ref_x;
    logic signed [23:0] ref_y;
    logic signed [23:0] px[$];
    logic signed [23:0] py[$];
    logic signed [63:0] strip[$];
    logic signed [63:0] area_sum;
    logic [1:0] exp_status[$];
    logic signed [63:0] exp_area[$];
    logic [6:0] exp_count[$];
    int errors;

    function new(int unsigned cap);
        capacity = cap;
        ref_x = '0;
        ref_y = '0;
        area_sum = '0;
        errors = 0;
    endfunction

    function void refresh_strip(int i);
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        dx = 64'(px[i]) - 64'(ref_x);
        if (i + 1 >= px.size())
            dy = 64'(py[i]) - 64'(ref_y);
        else
            dy = 64'(py[i]) - 64'(py[i + 1]);
        area_sum = pfh_pkg::sat_sub(area_sum, strip[i]);
        strip[i] = dx * dy;
        area_sum = pfh_pkg::sat_add(area_sum, strip[i]);
    endfunction

    function logic [1:0] insert_point(logic signed [23:0] cx, logic signed [23:0] cy);
        int pos;
        int k;
        pos = 0;
        while (pos < px.size() && px[pos] < cx)
            pos++;
        if (pos < px.size() && py[pos] >= cy)
            return pfh_pkg::ST_DOMINATED;
        if (pos < px.size() && px[pos] == cx)
            py[pos] = cy;
        else
        begin
            if (px.size() >= capacity)
                return pfh_pkg::ST_FULL;
            px.insert(pos, cx);
            py.insert(pos, cy);
            strip.insert(pos, 64'sd0);
        end
        refresh_strip(pos);
        k = pos;
        while (k > 0 && py[k - 1] <= cy)
        begin
            k--;
            area_sum = pfh_pkg::sat_sub(area_sum, strip[k]);
            px.delete(k);
            py.delete(k);
            strip.delete(k);
        end
        if (k > 0)
            refresh_strip(k - 1);
        return pfh_pkg::ST_ACCEPTED;
    endfunction

    function void note_command(logic op, logic signed [23:0] cx, logic signed [23:0] cy);
        logic [1:0] st;
        if (op == pfh_pkg::OP_CLEAR)
        begin
            px.delete();
            py.delete();
            strip.delete();
            area_sum = '0;
            st = pfh_pkg::ST_CLEARED;
        end
        else
            st = insert_point(cx, cy);
        exp_status.push_back(st);
        exp_area.push_back(area_sum);
        exp_count.push_back(7'(px.size()));
    endfunction

    function void check_result(logic [1:0] st, logic signed [63:0] area, logic [6:0] cnt);
        if (exp_status.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: status %0d area %0d count %0d", st, area, cnt);
            return;
        end
        if (st !== exp_status[0] || area !== exp_area[0] || cnt !== exp_count[0])
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: status %0d/%0d area %0d/%0d count %0d/%0d",
                    exp_status[0], st, exp_area[0], area, exp_count[0], cnt);
        end
        void'(exp_status.pop_front());
        void'(exp_area.pop_front());
        void'(exp_count.pop_front());
    endfunction
endclass

module tb_top;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic op;
    logic signed [23:0] cand_x;
    logic signed [23:0] cand_y;
    logic result_valid;
    logic [1:0] status;
    logic signed [63:0] total_area;
    logic [6:0] entry_count;
    logic cfg_valid;
    logic cfg_ready;
    logic [pfh_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [23:0] cfg_data;

    front_scoreboard sb;
    int cycles;
    int step_x;
    int step_y;

    pareto_front_2d_hypervolume dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .cand_x(cand_x), .cand_y(cand_y), .result_valid(result_valid),
        .status(status), .total_area(total_area), .entry_count(entry_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 600000)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(status, total_area, entry_count);
    end

    task automatic send_command(logic o, logic signed [23:0] x, logic signed [23:0] y);
        start <= 1'b1;
        op <= o;
        cand_x <= x;
        cand_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(o, x, y);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.exp_status.size() != 0)
            @(posedge clk);
        idle_cycles(300);
    endtask

    task automatic write_reg(logic [pfh_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == pfh_pkg::REG_REF_X)
            sb.ref_x = val;
        else
            sb.ref_y = val;
    endtask

    task automatic write_ref_point(logic [23:0] x, logic [23:0] y);
        write_reg(pfh_pkg::REG_REF_X, x);
        write_reg(pfh_pkg::REG_REF_Y, y);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom);
            default: return 24'($urandom_range(0, 4095)) - 24'sd1000;
        endcase
    endfunction

    task automatic random_phase(int n);
        int burst;
        int x;
        int y;
        for (int i = 0; i < n; )
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && i < n; b++, i++)
            begin
                if ($urandom_range(0, 60) == 0)
                    send_command(pfh_pkg::OP_CLEAR, 24'($urandom), 24'($urandom));
                else if ($urandom_range(0, 4) == 0)
                    send_command(pfh_pkg::OP_INSERT, rand_coord(), rand_coord());
                else
                begin
                    x = $urandom_range(0, 3000);
                    y = 3000 - x + $urandom_range(0, 400) - 200;
                    send_command(pfh_pkg::OP_INSERT, 24'(x), 24'(y));
                end
            end
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                idle_cycles($urandom_range(1, 15));
            end
        end
    endtask

    initial
    begin
        sb = new(pfh_pkg::CAPACITY_DEF);
        rst_n = 1'b0;
        start = 1'b0;
        op = pfh_pkg::OP_INSERT;
        cand_x = '0;
        cand_y = '0;
        cfg_valid = 1'b0;
        cfg_index = pfh_pkg::REG_REF_X;
        cfg_data = '0;
        idle_cycles(10);
        rst_n <= 1'b1;
        idle_cycles(2);

        send_command(pfh_pkg::OP_INSERT, 24'sd100, 24'sd100);
        send_command(pfh_pkg::OP_INSERT, 24'sd100, 24'sd100);
        send_command(pfh_pkg::OP_INSERT, 24'sd50, 24'sd50);
        send_command(pfh_pkg::OP_INSERT, 24'sd100, 24'sd200);
        send_command(pfh_pkg::OP_INSERT, 24'sd200, 24'sd50);
        send_command(pfh_pkg::OP_INSERT, 24'sd20, 24'sd300);
        send_command(pfh_pkg::OP_INSERT, 24'sd150, 24'sd400);
        send_command(pfh_pkg::OP_INSERT, 24'sh7FFFFF, 24'sh7FFFFF);
        send_command(pfh_pkg::OP_INSERT, 24'sh800000, 24'sh800000);
        send_command(pfh_pkg::OP_INSERT, 24'sh800000, 24'sh7FFFFF);
        send_command(pfh_pkg::OP_INSERT, -24'sd5, -24'sd5);
        send_command(pfh_pkg::OP_CLEAR, 24'sh7FFFFF, 24'sh800000);
        for (int i = 0; i < 66; i++)
            send_command(pfh_pkg::OP_INSERT, 24'(i * 10), 24'(1000 - i * 10));
        send_command(pfh_pkg::OP_INSERT, 24'sd5, 24'sd0);
        send_command(pfh_pkg::OP_INSERT, 24'sd5, 24'sd2000);
        send_command(pfh_pkg::OP_CLEAR, 24'sd0, 24'sd0);
        drain();

        write_ref_point(24'h800000, 24'h800000);
        for (int i = 0; i < 4; i++)
            send_command(pfh_pkg::OP_INSERT, 24'sh7FFFFF - 24'(i), 24'sh7FFFFF - 24'(i));
        send_command(pfh_pkg::OP_INSERT, 24'sh7FFFF0, 24'sh7FFFFF);
        send_command(pfh_pkg::OP_CLEAR, 24'sd0, 24'sd0);
        random_phase(150);
        drain();

        write_ref_point(24'h7FFFFF, 24'h7FFFFF);
        random_phase(100);
        drain();

        step_x = $urandom_range(0, 500);
        step_y = $urandom_range(0, 500);
        write_ref_point(24'(step_x - 250), 24'(step_y - 250));
        send_command(pfh_pkg::OP_CLEAR, 24'sd0, 24'sd0);
        random_phase(200);
        drain();

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
